FILE: design/ncv_pkg.sv
// Package for the normalized 2D convolution block.
// Holds sizes, word structs, control structs and the modulo-rows and line store address helpers.
// Used by ncv_mac, ncv_div and normalized_2d_convolution.
package ncv_pkg;

  localparam int MAX_DIM    = 32;
  localparam int MAX_KERNEL = 7;
  localparam int DATA_WIDTH = 16;

  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int CFG_W      = 6;
  localparam int K_W        = 3;
  localparam int KMEM_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int KIDX_W     = $clog2(KMEM_DEPTH);
  localparam int LMEM_DEPTH = MAX_KERNEL * MAX_DIM;
  localparam int LS_AW      = $clog2(LMEM_DEPTH);
  localparam int RM_W       = $clog2(MAX_KERNEL);
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int ACC_W      = 37;
  localparam int WSUM_W     = 22;
  localparam int DCNT_W     = $clog2(ACC_W + 1);
  localparam int CIDX_W     = 2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_KSIZE  = 2'd2;

  // Input opcodes.
  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  typedef struct packed {
    logic                         opcode;
    logic signed [DATA_WIDTH-1:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] filtered_value;
    logic [DIM_W-1:0]        out_row;
    logic [DIM_W-1:0]        out_col;
    logic                    last_of_image;
    logic                    divide_error;
  } out_word_t;

  // Store write requests from the top level to the MAC unit.
  typedef struct packed {
    logic                         kw_en;
    logic [KIDX_W-1:0]            kw_addr;
    logic                         pw_en;
    logic [LS_AW-1:0]             pw_addr;
    logic signed [DATA_WIDTH-1:0] data;
  } mac_wr_t;

  // Window start request: kernel side and top-left corner of the window.
  typedef struct packed {
    logic             start;
    logic [K_W-1:0]   k;
    logic [DIM_W-1:0] r0;
    logic [DIM_W-1:0] c0;
  } mac_start_t;

  // Row modulo the line store depth, for row numbers below 8 * MAX_KERNEL.
  function automatic logic [RM_W-1:0] row_mod(input logic [DIM_W-1:0] r);
    logic [DIM_W-1:0] v;
    v = r;
    if (v >= DIM_W'(4 * MAX_KERNEL)) v = v - DIM_W'(4 * MAX_KERNEL);
    if (v >= DIM_W'(2 * MAX_KERNEL)) v = v - DIM_W'(2 * MAX_KERNEL);
    if (v >= DIM_W'(MAX_KERNEL))     v = v - DIM_W'(MAX_KERNEL);
    return v[RM_W-1:0];
  endfunction

  // Line store address of a row (already reduced) and a column.
  function automatic logic [LS_AW-1:0] ls_addr(input logic [RM_W-1:0] rm,
                                               input logic [DIM_W-1:0] c);
    return LS_AW'(rm * MAX_DIM) + LS_AW'(c);
  endfunction

endpackage

FILE: design/ncv_mac.sv
// Kernel store, line store and the shared multiply-accumulate unit.
// Walks one window tap per cycle through a read, multiply, add pipeline.
// Depends on ncv_pkg.
module ncv_mac import ncv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_wr_t                 wr_i,
  input  mac_start_t              st_i,
  output logic                    done_o,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [DATA_WIDTH-1:0] kmem [KMEM_DEPTH];
  logic signed [DATA_WIDTH-1:0] lmem [LMEM_DEPTH];

  logic                         busy_r, issuing_r, v1_r, v2_r;
  logic [K_W-1:0]               i_r, j_r, k_r;
  logic [KIDX_W-1:0]            kidx_r;
  logic [RM_W-1:0]              rm_r;
  logic [DIM_W-1:0]             c0_r;
  logic signed [DATA_WIDTH-1:0] ks_q_r, ls_q_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic                         last_tap;
  logic [LS_AW-1:0]             rd_addr;

  assign last_tap = (i_r == k_r - K_W'(1)) && (j_r == k_r - K_W'(1));
  assign rd_addr  = ls_addr(rm_r, DIM_W'(c0_r + DIM_W'(j_r)));
  assign done_o   = busy_r && !issuing_r && !v1_r && !v2_r;
  assign acc_o    = acc_r;

  // Store writes and registered reads of the current tap.
  always_ff @(posedge clk) begin
    if (wr_i.kw_en) kmem[wr_i.kw_addr] <= wr_i.data;
    if (wr_i.pw_en) lmem[wr_i.pw_addr] <= wr_i.data;
    if (issuing_r) begin
      ks_q_r <= kmem[kidx_r];
      ls_q_r <= lmem[rd_addr];
    end
  end

  // Tap sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      issuing_r <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      v1_r <= issuing_r;
      v2_r <= v1_r;
      if (st_i.start) begin
        busy_r    <= 1'b1;
        issuing_r <= 1'b1;
        i_r       <= '0;
        j_r       <= '0;
        kidx_r    <= '0;
        k_r       <= st_i.k;
        rm_r      <= row_mod(st_i.r0);
        c0_r      <= st_i.c0;
      end else if (issuing_r) begin
        kidx_r <= kidx_r + KIDX_W'(1);
        if (j_r == k_r - K_W'(1)) begin
          j_r  <= '0;
          i_r  <= i_r + K_W'(1);
          rm_r <= (rm_r == RM_W'(MAX_KERNEL - 1)) ? '0 : rm_r + RM_W'(1);
        end else begin
          j_r <= j_r + K_W'(1);
        end
        if (last_tap) issuing_r <= 1'b0;
      end else if (done_o) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Multiply, then accumulate.
  always_ff @(posedge clk) begin
    prod_r <= ks_q_r * ls_q_r;
    if (st_i.start) acc_r <= '0;
    else if (v2_r) acc_r <= acc_r + ACC_W'(prod_r);
  end

endmodule

FILE: design/ncv_div.sv
// Serial restoring divider, one quotient bit per cycle, signed operands.
// Truncates toward zero; a zero divisor gives zero and sets the error flag.
// Depends on ncv_pkg.
module ncv_div import ncv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start_i,
  input  logic signed [ACC_W-1:0]  dividend_i,
  input  logic signed [WSUM_W-1:0] divisor_i,
  output logic                     done_o,
  output logic signed [ACC_W-1:0]  quotient_o,
  output logic                     err_o
);

  logic              busy_r, done_r, neg_r, err_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [WSUM_W-1:0] rem_r, dv_r;
  logic [ACC_W-1:0]  quo_r;
  logic [WSUM_W:0]   rem_sh, diff;

  assign rem_sh     = {rem_r, quo_r[ACC_W-1]};
  assign diff       = rem_sh - {1'b0, dv_r};
  assign done_o     = done_r;
  assign err_o      = err_r;
  assign quotient_o = neg_r ? -$signed(quo_r) : $signed(quo_r);

  // Control and datapath of the shift-subtract loop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        if (divisor_i == '0) begin
          err_r  <= 1'b1;
          neg_r  <= 1'b0;
          quo_r  <= '0;
          done_r <= 1'b1;
        end else begin
          err_r  <= 1'b0;
          neg_r  <= dividend_i[ACC_W-1] ^ divisor_i[WSUM_W-1];
          quo_r  <= dividend_i[ACC_W-1] ? ACC_W'(-dividend_i) : ACC_W'(dividend_i);
          dv_r   <= divisor_i[WSUM_W-1] ? WSUM_W'(-divisor_i) : WSUM_W'(divisor_i);
          rem_r  <= '0;
          cnt_r  <= DCNT_W'(ACC_W);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (!diff[WSUM_W]) begin
          rem_r <= diff[WSUM_W-1:0];
          quo_r <= {quo_r[ACC_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[WSUM_W-1:0];
          quo_r <= {quo_r[ACC_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/normalized_2d_convolution.sv
// Normalized valid-mode 2D convolution. A kernel weight word and a pixel word that
// completes no window are taken without stalling the input. A pixel word that
// completes a k x k window holds the input stalled while the window is processed:
// the shared multiply-accumulate unit walks the k*k taps, one tap per cycle through
// the single read port of each store, the pipeline drains and hands off, the
// one-bit-per-cycle divider runs with its done cycle, and the output register is
// loaded once it is free. A finished result sits in the output register, so the
// next word is taken while it waits.
// Depends on ncv_pkg, ncv_mac and ncv_div.
module normalized_2d_convolution import ncv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_DIV, S_OUT} state_t;

  state_t                  state_r;
  logic [CFG_W-1:0]        height_r, width_r;
  logic [K_W-1:0]          ksize_r;
  logic [KIDX_W-1:0]       widx_r;
  logic signed [WSUM_W-1:0] wsum_r;
  logic [DIM_W-1:0]        prow_r, pcol_r, orow_r, ocol_r;
  logic                    last_r;
  logic                    out_valid_r;
  out_word_t               out_r;

  logic [K_W-1:0]          k_eff;
  logic [CFG_W-1:0]        h_eff, w_eff;
  logic [KIDX_W-1:0]       kk, wi, wi_inc;
  logic                    accept, win_hit, col_end, row_end, out_free;
  logic [DIM_W-1:0]        r0, c0;
  mac_wr_t                 wr;
  mac_start_t              st;
  logic                    mac_done, div_done, div_err;
  logic signed [ACC_W-1:0] acc, quo;

  // Effective sizes after clamping.
  assign k_eff = (ksize_r == '0) ? K_W'(1) : ksize_r;
  assign h_eff = (height_r == '0) ? CFG_W'(1) :
                 (height_r > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : height_r;
  assign w_eff = (width_r == '0) ? CFG_W'(1) :
                 (width_r > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : width_r;
  assign kk    = KIDX_W'(k_eff * k_eff);

  // Handshake.
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Weight index with wrap before and after the write.
  assign wi     = (widx_r >= kk) ? '0 : widx_r;
  assign wi_inc = KIDX_W'(wi + KIDX_W'(1));

  // Pixel position tests.
  assign col_end = (CFG_W'(pcol_r) + CFG_W'(1)) >= w_eff;
  assign row_end = (CFG_W'(prow_r) + CFG_W'(1)) >= h_eff;
  assign win_hit = (prow_r >= DIM_W'(k_eff - K_W'(1))) &&
                   (pcol_r >= DIM_W'(k_eff - K_W'(1)));
  assign r0      = DIM_W'(prow_r - DIM_W'(k_eff - K_W'(1)));
  assign c0      = DIM_W'(pcol_r - DIM_W'(k_eff - K_W'(1)));

  // Store writes and window start.
  always_comb begin
    wr.kw_en   = accept && (in_data.opcode == OP_WEIGHT);
    wr.kw_addr = wi;
    wr.pw_en   = accept && (in_data.opcode == OP_PIXEL);
    wr.pw_addr = ls_addr(row_mod(prow_r), pcol_r);
    wr.data    = in_data.sample_value;
    st.start   = wr.pw_en && win_hit;
    st.k       = k_eff;
    st.r0      = r0;
    st.c0      = c0;
  end

  ncv_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_i   (wr),
    .st_i   (st),
    .done_o (mac_done),
    .acc_o  (acc)
  );

  ncv_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    ((state_r == S_MAC) && mac_done),
    .dividend_i (acc),
    .divisor_i  (wsum_r),
    .done_o     (div_done),
    .quotient_o (quo),
    .err_o      (div_err)
  );

  // Configuration registers, counters, sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      height_r    <= CFG_W'(8);
      width_r     <= CFG_W'(8);
      ksize_r     <= K_W'(3);
      widx_r      <= '0;
      wsum_r      <= '0;
      prow_r      <= '0;
      pcol_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEIGHT: height_r <= cfg_wdata;
          CFG_WIDTH:  width_r  <= cfg_wdata;
          CFG_KSIZE:  ksize_r  <= cfg_wdata[K_W-1:0];
          default:    ;
        endcase
      end
      // The output word is loaded from the result phase and dropped once taken.
      if ((state_r == S_OUT) && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (wr.kw_en) begin
            wsum_r <= (wi == '0) ? WSUM_W'(in_data.sample_value)
                                 : wsum_r + WSUM_W'(in_data.sample_value);
            widx_r <= (wi_inc >= kk) ? '0 : wi_inc;
          end
          if (wr.pw_en) begin
            orow_r <= r0;
            ocol_r <= c0;
            last_r <= row_end && col_end;
            if (col_end) begin
              pcol_r <= '0;
              prow_r <= row_end ? '0 : DIM_W'(prow_r + DIM_W'(1));
            end else begin
              pcol_r <= DIM_W'(pcol_r + DIM_W'(1));
            end
            if (win_hit) state_r <= S_MAC;
          end
        end
        S_MAC: if (mac_done) state_r <= S_DIV;
        S_DIV: if (div_done) state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_r.filtered_value <= quo;
            out_r.out_row        <= orow_r;
            out_r.out_col        <= ocol_r;
            out_r.last_of_image  <= last_r;
            out_r.divide_error   <= div_err;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV) else $error("divider finished outside divide phase");
  a_mac_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC && mac_done) |=> state_r == S_DIV)
    else $error("MAC completion did not start the divide");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.divide_error) |-> out_data.filtered_value == '0)
    else $error("divide error word carries a nonzero value");
  a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
    widx_r < KIDX_W'(KMEM_DEPTH)) else $error("weight index beyond kernel store");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the normalized 2D convolution block.
// Drives kernel and pixel words, predicts each filtered result and compares it.
// Depends on ncv_pkg and normalized_2d_convolution.
`timescale 1ns / 100ps

module tb_top;
  import ncv_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 150;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_data;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  normalized_2d_convolution u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Words waiting to be sent and filtered results waiting to arrive.
  in_word_t  pending_words[$];
  out_word_t expected_results[$];

  // Shadow of the block's configuration and state.
  logic [CFG_W-1:0] sh_height;
  logic [CFG_W-1:0] sh_width;
  logic [K_W-1:0]   sh_ksize;
  longint           kernel_w[KMEM_DEPTH];
  longint           line_px[LMEM_DEPTH];
  longint           weight_total;
  int               weight_pos;
  int               px_row;
  int               px_col;

  int  mismatches;
  int  stalled_cycles;
  int  words_made;
  bit  word_taken;
  int  burst_left;
  int  gap_left;
  int  stall_mode;
  int  stall_mode_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Effective kernel side and image size after clamping.
  function automatic int eff_k();
    return (sh_ksize == 0) ? 1 : ((sh_ksize > MAX_KERNEL) ? MAX_KERNEL : int'(sh_ksize));
  endfunction

  function automatic int eff_dim(input logic [CFG_W-1:0] d);
    return (d == 0) ? 1 : ((d > MAX_DIM) ? MAX_DIM : int'(d));
  endfunction

  // Update the shadow state with one accepted word and queue any result.
  function automatic void convolve_word(input in_word_t w);
    int        k;
    int        h;
    int        wd;
    int        r;
    int        c;
    longint    s;
    longint    acc;
    longint    q;
    out_word_t res;
    k  = eff_k();
    h  = eff_dim(sh_height);
    wd = eff_dim(sh_width);
    s  = longint'(w.sample_value);
    if (w.opcode == OP_WEIGHT) begin
      if (weight_pos >= k * k) weight_pos = 0;
      kernel_w[weight_pos] = s;
      weight_total = (weight_pos == 0) ? s : weight_total + s;
      weight_pos++;
      if (weight_pos >= k * k) weight_pos = 0;
      return;
    end
    r = px_row;
    c = px_col;
    line_px[(r % MAX_KERNEL) * MAX_DIM + c] = s;
    if (r + 1 >= k && c + 1 >= k) begin
      acc = 0;
      for (int i = 0; i < k; i++)
        for (int j = 0; j < k; j++)
          acc += line_px[((r + 1 - k + i) % MAX_KERNEL) * MAX_DIM + (c + 1 - k + j)]
                 * kernel_w[i * k + j];
      q = (weight_total != 0) ? acc / weight_total : 0;
      res.filtered_value = q[ACC_W-1:0];
      res.out_row        = DIM_W'(r + 1 - k);
      res.out_col        = DIM_W'(c + 1 - k);
      res.last_of_image  = (r + 1 >= h && c + 1 >= wd);
      res.divide_error   = (weight_total == 0);
      expected_results.push_back(res);
    end
    if (c + 1 >= wd) begin
      px_col = 0;
      px_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      px_col = c + 1;
    end
  endfunction

  // Accept monitor, result checker and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      stalled_cycles = stalled_cycles + 1;
      if (in_valid && !in_stall) begin
        convolve_word(pending_words.pop_front());
        word_taken = 1'b1;
        stalled_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        stalled_cycles = 0;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result word: %p", out_data);
        end else begin
          out_word_t e;
          e = expected_results.pop_front();
          if (e.filtered_value != out_data.filtered_value || e.out_row != out_data.out_row ||
              e.out_col != out_data.out_col || e.last_of_image != out_data.last_of_image ||
              e.divide_error != out_data.divide_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result mismatch: expected %p, got %p", e, out_data);
          end
        end
      end
      if (pending_words.size() == 0 && expected_results.size() == 0)
        stalled_cycles = 0;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL normalized_2d_convolution");
        $finish;
      end
    end
  end

  // Sender: bursts of words separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_words[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 60);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches among none, random and mostly stalled stretches.
  always @(negedge clk) begin
    if (stall_mode_left <= 0) begin
      stall_mode      = $urandom_range(0, 2);
      stall_mode_left = $urandom_range(100, 600);
    end
    stall_mode_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= ($urandom_range(0, 15) < 11);
    endcase
  end

  // Sample biased toward the extremes of the 16-bit range.
  function automatic logic [DATA_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 2)) - 1);
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  task automatic push_word(input logic op, input logic [DATA_WIDTH-1:0] v);
    in_word_t w;
    w.opcode       = op;
    w.sample_value = v;
    pending_words.push_back(w);
    words_made++;
  endtask

  task automatic push_pixels(input int n);
    for (int i = 0; i < n; i++) push_word(OP_PIXEL, pick_sample());
  endtask

  task automatic push_kernel(input int n);
    for (int i = 0; i < n; i++) push_word(OP_WEIGHT, pick_sample());
  endtask

  // Let all words go through and all results arrive, then let the block settle.
  task automatic drain();
    while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_HEIGHT: sh_height = v;
      CFG_WIDTH:  sh_width  = v;
      default:    sh_ksize  = v[K_W-1:0];
    endcase
  endtask

  task automatic set_shape(input int h, input int w, input int k);
    drain();
    write_reg(CFG_HEIGHT, CFG_W'(h));
    write_reg(CFG_WIDTH, CFG_W'(w));
    write_reg(CFG_KSIZE, CFG_W'(k));
  endtask

  // Stimulus and final verdict.
  initial begin
    int h;
    int w;
    int k;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_HEIGHT;
    cfg_wdata = '0;
    rst_n = 1'b0;
    sh_height = 8;
    sh_width = 8;
    sh_ksize = 3;
    weight_total = 0;
    weight_pos = 0;
    px_row = 0;
    px_col = 0;
    mismatches = 0;
    stalled_cycles = 0;
    words_made = 0;
    word_taken = 1'b0;
    burst_left = 1;
    gap_left = 0;
    stall_mode_left = 0;
    for (int i = 0; i < KMEM_DEPTH; i++) kernel_w[i] = 0;
    for (int i = 0; i < LMEM_DEPTH; i++) line_px[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset shape: extreme weights, then extreme pixels over one 8 x 8 image.
    push_word(OP_WEIGHT, 16'h7FFF);
    push_word(OP_WEIGHT, 16'h8000);
    push_word(OP_WEIGHT, 16'h0001);
    push_word(OP_WEIGHT, 16'h0000);
    push_word(OP_WEIGHT, 16'hFFFF);
    push_word(OP_WEIGHT, 16'h7FFF);
    push_word(OP_WEIGHT, 16'h8000);
    push_word(OP_WEIGHT, 16'h0005);
    push_word(OP_WEIGHT, 16'h0003);
    for (int i = 0; i < 64; i++)
      push_word(OP_PIXEL, (i % 3 == 0) ? 16'h7FFF : ((i % 3 == 1) ? 16'h8000 : 16'hFFFF));

    // Full 7 x 7 kernel and seven full-width rows fill every store entry.
    set_shape(7, 32, 7);
    push_kernel(49);
    push_pixels(7 * 32);

    // Weights that sum to zero give a divide error on every window.
    set_shape(4, 5, 3);
    for (int i = 0; i < 9; i++) push_word(OP_WEIGHT, (i % 2 == 0) ? 16'h0007 : 16'hFFF9);
    push_word(OP_WEIGHT, 16'h0000);
    push_word(OP_WEIGHT, 16'hFFFF);
    push_word(OP_WEIGHT, 16'h0001);
    push_pixels(20);

    // Zero sizes are treated as one; oversized ones clamp.
    set_shape(0, 63, 0);
    push_kernel(1);
    push_pixels(40);
    set_shape(63, 2, 1);
    push_kernel(2);
    push_pixels(70);

    // Kernel larger than the image completes no window.
    set_shape(3, 3, 5);
    push_kernel(25);
    push_pixels(12);

    // Random shapes, mostly small, with a few extra weights.
    while (words_made < 900) begin
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 9) == 0) begin
        h = $urandom_range(0, 63);
        w = $urandom_range(0, 63);
      end else begin
        h = $urandom_range(2, 10);
        w = $urandom_range(2, 10);
      end
      set_shape(h, w, k);
      if (eff_k() * eff_k() > 1 && $urandom_range(0, 5) == 0)
        push_kernel(eff_k() * eff_k() + $urandom_range(1, 3));
      else
        push_kernel(eff_k() * eff_k());
      h = eff_dim(CFG_W'(h));
      w = eff_dim(CFG_W'(w));
      if (h * w > 300) push_pixels($urandom_range(20, 120));
      else push_pixels(h * w * $urandom_range(1, 2) + (($urandom_range(0, 4) == 0) ?
                       $urandom_range(1, 7) : 0));
    end

    drain();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS normalized_2d_convolution");
    end else begin
      $display("FAIL normalized_2d_convolution");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ncv_pkg.sv
design/ncv_mac.sv
design/ncv_div.sv
design/normalized_2d_convolution.sv
tb/tb_top.sv
